/* src/bmst_pkg.sv */
// types, codes and default sizes shared by the membership set table
// no dependencies
package bmst_pkg;

   localparam int DEF_NUM_SETS  = 4;
   localparam int DEF_SET_DEPTH = 64;

   localparam int KEY_W   = 64;
   localparam int CAP_W   = 7;
   localparam int COUNT_W = 7;
   localparam int TOTAL_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [1:0] KIND_ADD      = 2'd0;
   localparam logic [1:0] KIND_FORGET   = 2'd1;
   localparam logic [1:0] KIND_CONTAINS = 2'd2;
   localparam logic [1:0] KIND_READ     = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam logic [1:0] CSR_LAYOUT_CAP = 2'd0;
   localparam logic [1:0] CSR_WIDGET_CAP = 2'd1;
   localparam logic [1:0] CSR_SHADER_CAP = 2'd2;

   typedef struct packed {
      logic [1:0]       kind;
      logic [3:0]       set_id;
      logic [KEY_W-1:0] object_key;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic [COUNT_W-1:0] member_count;
      logic [TOTAL_W-1:0] recorded_total;
      logic [TOTAL_W-1:0] refused_total;
      logic [TOTAL_W-1:0] forgotten_total;
   } rsp_type;

   typedef struct packed {
      logic [CAP_W-1:0] layout_capacity;
      logic [CAP_W-1:0] widget_capacity;
      logic [CAP_W-1:0] shader_capacity;
   } cap_cfg_type;

endpackage

/* src/bmst_key_ram.sv */
// key store: one write port, one read port with registered read data
// no dependencies
module bmst_key_ram #(
   parameter int ADDR_W = 8,
   parameter int DEPTH  = 256,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] key_mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= key_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/bmst_engine.sv */
// sequencer for the set table: scans the key store, updates fills and counters
// depends on bmst_pkg and bmst_key_ram
module bmst_engine #(
   parameter int NUM_SETS  = bmst_pkg::DEF_NUM_SETS,
   parameter int SET_DEPTH = bmst_pkg::DEF_SET_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bmst_pkg::req_type     req_item,
   input  bmst_pkg::cap_cfg_type cap_cfg,
   output logic                  rsp_valid,
   output bmst_pkg::rsp_type     rsp_item
);

   localparam int SET_W   = $clog2(NUM_SETS);
   localparam int IDX_W   = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int FILL_W  = $clog2(SET_DEPTH + 1);
   localparam int ADDR_W  = SET_W + IDX_W;
   localparam int MEM_DEPTH = NUM_SETS * (1 << IDX_W);
   localparam int CAP_W   = bmst_pkg::CAP_W;
   localparam int CMP_W   = (FILL_W > CAP_W) ? FILL_W : CAP_W;
   localparam int COUNT_W = bmst_pkg::COUNT_W;
   localparam int TOTAL_W = bmst_pkg::TOTAL_W;
   localparam int KEY_W   = bmst_pkg::KEY_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_MVRD = 3'd2;
   localparam logic [2:0] S_MVWR = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [1:0]         kind_ff, kind_in;
   logic [3:0]         set_ff, set_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [SET_W-1:0]   cur_set_ff, cur_set_in;
   logic [FILL_W-1:0]  idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [1:0]         status_ff, status_in;
   logic               found_ff, found_in;
   logic [FILL_W-1:0]  fill_ff [NUM_SETS];
   logic [FILL_W-1:0]  fill_in [NUM_SETS];
   logic [TOTAL_W-1:0] rec_ff [NUM_SETS];
   logic [TOTAL_W-1:0] rec_in [NUM_SETS];
   logic [TOTAL_W-1:0] ref_ff [NUM_SETS];
   logic [TOTAL_W-1:0] ref_in [NUM_SETS];
   logic [TOTAL_W-1:0] forgot_ff, forgot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bmst_pkg::rsp_type  rsp_ff, rsp_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [KEY_W-1:0]   wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [KEY_W-1:0]   rd_data;

   logic               cur_ok;
   logic [FILL_W-1:0]  fill_cur;
   logic [FILL_W-1:0]  last_cur;
   logic [CAP_W-1:0]   cap_cur;
   logic               set_full;
   logic               hit;
   logic               issue;
   logic               req_set_ok;
   logic               held_set_ok;
   logic               last_set;

   bmst_key_ram #(
      .ADDR_W (ADDR_W),
      .DEPTH  (MEM_DEPTH),
      .DATA_W (KEY_W)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cur_ok      = (32'(cur_set_ff) < NUM_SETS);
   assign fill_cur    = cur_ok ? fill_ff[cur_set_ff] : '0;
   assign last_cur    = fill_cur - FILL_W'(1);
   assign req_set_ok  = ({1'b0, req_item.set_id} < 5'(NUM_SETS));
   assign held_set_ok = ({1'b0, set_ff} < 5'(NUM_SETS));
   assign last_set    = (cur_set_ff == SET_W'(NUM_SETS - 1));

   always_comb begin
      if (cur_set_ff < SET_W'(2)) begin
         cap_cur = cap_cfg.layout_capacity;
      end else if (cur_set_ff == SET_W'(2)) begin
         cap_cur = cap_cfg.widget_capacity;
      end else begin
         cap_cur = cap_cfg.shader_capacity;
      end
   end

   assign set_full = (CMP_W'(fill_cur) >= CMP_W'(cap_cur)) ||
                     (fill_cur >= FILL_W'(SET_DEPTH));
   assign hit      = pend_ff && (rd_data == key_ff);
   assign issue    = !hit && (idx_ff < fill_cur);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      set_in       = set_ff;
      key_in       = key_ff;
      cur_set_in   = cur_set_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      fill_in      = fill_ff;
      rec_in       = rec_ff;
      ref_in       = ref_ff;
      forgot_in    = forgot_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = {cur_set_ff, pos_ff};
      wr_data      = key_ff;
      rd_addr      = {cur_set_ff, idx_ff[IDX_W-1:0]};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in    = req_item.kind;
               set_in     = req_item.set_id;
               key_in     = req_item.object_key;
               found_in   = 1'b0;
               status_in  = bmst_pkg::STATUS_OK;
               idx_in     = '0;
               pend_in    = 1'b0;
               cur_set_in = req_item.set_id[SET_W-1:0];
               state_in   = S_RESP;
               case (req_item.kind)
                  bmst_pkg::KIND_ADD, bmst_pkg::KIND_CONTAINS: begin
                     if (!req_set_ok || (req_item.object_key == '0)) begin
                        status_in = bmst_pkg::STATUS_INVALID;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  bmst_pkg::KIND_FORGET: begin
                     if (req_item.object_key == '0) begin
                        status_in = bmst_pkg::STATUS_INVALID;
                     end else begin
                        cur_set_in = '0;
                        state_in   = S_SCAN;
                     end
                  end
                  default: begin
                     if (!req_set_ok) begin
                        status_in = bmst_pkg::STATUS_INVALID;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            pend_in = issue;
            if (issue) begin
               pend_idx_in = idx_ff[IDX_W-1:0];
               idx_in      = idx_ff + FILL_W'(1);
            end
            if (hit) begin
               case (kind_ff)
                  bmst_pkg::KIND_FORGET: begin
                     pos_in   = pend_idx_ff;
                     state_in = S_MVRD;
                  end
                  bmst_pkg::KIND_CONTAINS: begin
                     found_in = 1'b1;
                     state_in = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end else if (!issue) begin
               case (kind_ff)
                  bmst_pkg::KIND_FORGET: begin
                     idx_in  = '0;
                     pend_in = 1'b0;
                     if (last_set) begin
                        cur_set_in = set_ff[SET_W-1:0];
                        state_in   = S_RESP;
                     end else begin
                        cur_set_in = cur_set_ff + SET_W'(1);
                     end
                  end
                  bmst_pkg::KIND_ADD: begin
                     if (set_full) begin
                        ref_in[cur_set_ff] = ref_ff[cur_set_ff] + TOTAL_W'(1);
                        status_in          = bmst_pkg::STATUS_FULL;
                     end else begin
                        wr_en               = 1'b1;
                        wr_addr             = {cur_set_ff, fill_cur[IDX_W-1:0]};
                        fill_in[cur_set_ff] = fill_cur + FILL_W'(1);
                        rec_in[cur_set_ff]  = rec_ff[cur_set_ff] + TOTAL_W'(1);
                     end
                     state_in = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_MVRD: begin
            rd_addr  = {cur_set_ff, last_cur[IDX_W-1:0]};
            state_in = S_MVWR;
         end
         S_MVWR: begin
            wr_en               = 1'b1;
            wr_addr             = {cur_set_ff, pos_ff};
            wr_data             = rd_data;
            fill_in[cur_set_ff] = last_cur;
            forgot_in           = forgot_ff + TOTAL_W'(1);
            idx_in              = '0;
            pend_in             = 1'b0;
            if (last_set) begin
               cur_set_in = set_ff[SET_W-1:0];
               state_in   = S_RESP;
            end else begin
               cur_set_in = cur_set_ff + SET_W'(1);
               state_in   = S_SCAN;
            end
         end
         S_RESP: begin
            rsp_in.status          = status_ff;
            rsp_in.found           = found_ff;
            rsp_in.forgotten_total = forgot_ff;
            if (held_set_ok) begin
               rsp_in.member_count   = COUNT_W'(fill_cur);
               rsp_in.recorded_total = rec_ff[cur_set_ff];
               rsp_in.refused_total  = ref_ff[cur_set_ff];
            end else begin
               rsp_in.member_count   = '0;
               rsp_in.recorded_total = '0;
               rsp_in.refused_total  = '0;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         forgot_ff    <= '0;
         for (int s = 0; s < NUM_SETS; s++) begin
            fill_ff[s] <= '0;
            rec_ff[s]  <= '0;
            ref_ff[s]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         forgot_ff    <= forgot_in;
         fill_ff      <= fill_in;
         rec_ff       <= rec_in;
         ref_ff       <= ref_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      set_ff      <= set_in;
      key_ff      <= key_in;
      cur_set_ff  <= cur_set_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* src/bounded_membership_set_table_core.sv */
// top level of the bounded membership set table: capacity registers and engine
// depends on bmst_pkg and bmst_engine
//
// usage:
//   an item (kind, set_id, object_key on req_item) is taken at a clock edge with
//   start high and busy low. busy stays high until the item is finished.
//   exactly one result comes back on rsp_item, marked by rsp_valid for one
//   cycle; the receiver has no way to hold it off and must take it then.
//   capacities are written on csr_we / csr_index / csr_wdata while idle:
//   index 0 layout sets, 1 widget set, 2 shader sets; other indexes are ignored.
// handling, from the accepting edge to the result:
//   read counters and invalid items go straight to the result.
//   add and contains scan the addressed set; add stores a new key if the set has room.
//   forget scans every set and fills a removed key's slot with the set's last key.
//   the scan reads one key per cycle from a single read port of the key store.
//   a new item can be taken in the cycle its predecessor's result is shown.
// reset clears fills, counters and capacities (back to 64); the key store
//   itself is not cleared, only entries below a set's fill are ever read.
module bounded_membership_set_table_core #(
   parameter int NUM_SETS  = bmst_pkg::DEF_NUM_SETS,
   parameter int SET_DEPTH = bmst_pkg::DEF_SET_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  bmst_pkg::req_type           req_item,
   output logic                        rsp_valid,
   output bmst_pkg::rsp_type           rsp_item,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [bmst_pkg::CAP_W-1:0]  csr_wdata
);

   bmst_pkg::cap_cfg_type cap_ff, cap_in;

   always_comb begin
      cap_in = cap_ff;
      if (csr_we) begin
         case (csr_index)
            bmst_pkg::CSR_LAYOUT_CAP: cap_in.layout_capacity = csr_wdata;
            bmst_pkg::CSR_WIDGET_CAP: cap_in.widget_capacity = csr_wdata;
            bmst_pkg::CSR_SHADER_CAP: cap_in.shader_capacity = csr_wdata;
            default: cap_in = cap_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff.layout_capacity <= bmst_pkg::CAP_RESET;
         cap_ff.widget_capacity <= bmst_pkg::CAP_RESET;
         cap_ff.shader_capacity <= bmst_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   bmst_engine #(
      .NUM_SETS  (NUM_SETS),
      .SET_DEPTH (SET_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .cap_cfg   (cap_ff),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
